// ===== rtl/assert_macros.svh =====
// Assertion macros used by the attention unit controller.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SDA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define SDA_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/sda_pkg.sv =====
// Shared types and constants of the attention unit.
// No dependencies; imported by the controller, datapath and top level.
package sda_pkg;

	localparam int CNT_W      = 9;
	localparam int FUNC_W     = 3;
	localparam int ROW_W      = 6;
	localparam int COL_W      = 6;
	localparam int OUT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD_Q  = 3'd0,
		FN_LOAD_K  = 3'd1,
		FN_LOAD_V  = 3'd2,
		FN_LOAD_M  = 3'd3,
		FN_COMPUTE = 3'd4
	} func_t;

	localparam logic [CFG_IDX_W-1:0] REG_SEQ    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAUSAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd4;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [15:0] EXP_C1    = 16'd43025;
	localparam logic [13:0] EXP_C2    = 14'd10257;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_START,
		OP_DOT_RD,
		OP_DOT_MUL,
		OP_DOT_ACC,
		OP_SC1,
		OP_SC2,
		OP_SC3,
		OP_SC4,
		OP_EX_RD,
		OP_EX_A,
		OP_EX_B,
		OP_EX_C,
		OP_EX_D,
		OP_EX_E,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_PR_RD,
		OP_PR_MUL,
		OP_PR_WR,
		OP_OUT_RD,
		OP_OUT_MUL,
		OP_OUT_ACC,
		OP_OUT_RND,
		OP_OUT_ZERO
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             load;
		logic             first;
		logic             last;
		logic [CNT_W-1:0] j;
		logic [CNT_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic any;
	} sts_t;

endpackage

// ===== rtl/sda_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; used for every store of the attention unit.
module sda_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/sda_ctrl.sv =====
// Attention sequencer: scores, exp, reciprocal, probabilities, outputs, or zero rows.
// Depends on sda_pkg and assert_macros.svh; drives sda_datapath by command struct.
`include "assert_macros.svh"
module sda_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [sda_pkg::FUNC_W-1:0] in_func,
	input  logic [sda_pkg::ROW_W-1:0]  in_row,
	input  logic [sda_pkg::CNT_W-1:0]  sl,
	input  logic [sda_pkg::CNT_W-1:0]  hd,
	input  logic                       out_ready,
	input  sda_pkg::sts_t              sts,
	output logic                       in_ready,
	output logic                       out_valid,
	output sda_pkg::cmd_t              cmd
);
	import sda_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_D_RD, S_D_MUL, S_D_ACC, S_SC1, S_SC2, S_SC3, S_SC4, S_CHK,
		S_E_RD, S_E_A, S_E_B, S_E_C, S_E_D, S_E_E, S_DV_I, S_DV_S,
		S_P_RD, S_P_MUL, S_P_WR, S_O_RD, S_O_MUL, S_O_ACC, S_O_RND, S_O_WAIT,
		S_Z, S_Z_WAIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	logic             start;
	logic             j_end_s;
	logic             j_end_h;
	logic             k_end_s;
	logic             k_end_h;

	assign start   = in_valid && (in_func == FN_COMPUTE) && (CNT_W'(in_row) < sl);
	assign j_end_s = (j_q == sl - CNT_W'(1));
	assign j_end_h = (j_q == hd - CNT_W'(1));
	assign k_end_s = (k_q == sl - CNT_W'(1));
	assign k_end_h = (k_q == hd - CNT_W'(1));

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_O_WAIT) || (state_q == S_Z_WAIT);

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.load  = 1'b0;
		cmd.first = 1'b0;
		cmd.last  = j_end_h;
		cmd.j     = j_q;
		cmd.k     = k_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid && (in_func <= FN_LOAD_M);
				cmd.op   = start ? OP_START : OP_NONE;
			end
			S_D_RD:   cmd.op = OP_DOT_RD;
			S_D_MUL:  cmd.op = OP_DOT_MUL;
			S_D_ACC: begin
				cmd.op    = OP_DOT_ACC;
				cmd.first = (k_q == '0);
			end
			S_SC1:    cmd.op = OP_SC1;
			S_SC2:    cmd.op = OP_SC2;
			S_SC3:    cmd.op = OP_SC3;
			S_SC4: begin
				cmd.op    = OP_SC4;
				cmd.first = (j_q == '0);
			end
			S_CHK:    cmd.op = OP_NONE;
			S_E_RD:   cmd.op = OP_EX_RD;
			S_E_A:    cmd.op = OP_EX_A;
			S_E_B:    cmd.op = OP_EX_B;
			S_E_C:    cmd.op = OP_EX_C;
			S_E_D:    cmd.op = OP_EX_D;
			S_E_E: begin
				cmd.op    = OP_EX_E;
				cmd.first = (j_q == '0);
			end
			S_DV_I:   cmd.op = OP_DIV_INIT;
			S_DV_S: begin
				cmd.op    = OP_DIV_STEP;
				cmd.first = (k_q == '0);
			end
			S_P_RD:   cmd.op = OP_PR_RD;
			S_P_MUL:  cmd.op = OP_PR_MUL;
			S_P_WR:   cmd.op = OP_PR_WR;
			S_O_RD:   cmd.op = OP_OUT_RD;
			S_O_MUL:  cmd.op = OP_OUT_MUL;
			S_O_ACC: begin
				cmd.op    = OP_OUT_ACC;
				cmd.first = (k_q == '0);
			end
			S_O_RND:  cmd.op = OP_OUT_RND;
			S_O_WAIT: cmd.op = OP_NONE;
			S_Z:      cmd.op = OP_OUT_ZERO;
			S_Z_WAIT: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					j_q <= '0;
					k_q <= '0;
					if (start) begin
						state_q <= S_D_RD;
					end
				end
				S_D_RD:  state_q <= S_D_MUL;
				S_D_MUL: state_q <= S_D_ACC;
				S_D_ACC: begin
					if (k_end_h) begin
						k_q     <= '0;
						state_q <= S_SC1;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_D_RD;
					end
				end
				S_SC1: state_q <= S_SC2;
				S_SC2: state_q <= S_SC3;
				S_SC3: state_q <= S_SC4;
				S_SC4: begin
					if (j_end_s) begin
						j_q     <= '0;
						state_q <= S_CHK;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_D_RD;
					end
				end
				S_CHK:  state_q <= sts.any ? S_E_RD : S_Z;
				S_E_RD: state_q <= S_E_A;
				S_E_A:  state_q <= S_E_B;
				S_E_B:  state_q <= S_E_C;
				S_E_C:  state_q <= S_E_D;
				S_E_D:  state_q <= S_E_E;
				S_E_E: begin
					if (j_end_s) begin
						j_q     <= '0;
						state_q <= S_DV_I;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_E_RD;
					end
				end
				S_DV_I: begin
					k_q     <= '0;
					state_q <= S_DV_S;
				end
				S_DV_S: begin
					if (k_q == CNT_W'(32)) begin
						k_q     <= '0;
						state_q <= S_P_RD;
					end else begin
						k_q <= k_q + CNT_W'(1);
					end
				end
				S_P_RD:  state_q <= S_P_MUL;
				S_P_MUL: state_q <= S_P_WR;
				S_P_WR: begin
					if (j_end_s) begin
						j_q     <= '0;
						state_q <= S_O_RD;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_P_RD;
					end
				end
				S_O_RD:  state_q <= S_O_MUL;
				S_O_MUL: state_q <= S_O_ACC;
				S_O_ACC: begin
					if (k_end_s) begin
						k_q     <= '0;
						state_q <= S_O_RND;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_O_RD;
					end
				end
				S_O_RND: state_q <= S_O_WAIT;
				S_O_WAIT: begin
					if (out_ready) begin
						if (j_end_h) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + CNT_W'(1);
							state_q <= S_O_RD;
						end
					end
				end
				S_Z: state_q <= S_Z_WAIT;
				S_Z_WAIT: begin
					if (out_ready) begin
						if (j_end_h) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + CNT_W'(1);
							state_q <= S_Z;
						end
					end
				end
			endcase
		end
	end

	`SDA_NEVER(a_no_overlap, clk, arst_n, in_ready && out_valid, "input taken while result held")
	`SDA_ASSERT(a_last_idle, clk, arst_n, out_valid && out_ready && cmd.last |=> state_q == S_IDLE, "row did not end on last beat")
	`SDA_ASSERT(a_div_bound, clk, arst_n, state_q == S_DV_S |-> k_q <= CNT_W'(32), "divider overran")

endmodule

// ===== rtl/sda_datapath.sv =====
// Datapath of the attention unit: stores, dot products, exp, divider, output MAC.
// Depends on sda_pkg and sda_ram; commanded by sda_ctrl.
module sda_datapath #(
	parameter int MAX_SEQ    = 64,
	parameter int MAX_HEAD   = 64,
	parameter int DATA_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sda_pkg::cmd_t                    cmd,
	output sda_pkg::sts_t                    sts,
	input  logic [sda_pkg::FUNC_W-1:0]       in_func,
	input  logic [sda_pkg::ROW_W-1:0]        in_row,
	input  logic [sda_pkg::COL_W-1:0]        in_col,
	input  logic signed [DATA_WIDTH-1:0]     in_value,
	input  logic [15:0]                      scale,
	input  logic                             causal,
	input  logic                             mask_en,
	output logic signed [sda_pkg::OUT_W-1:0] out_value,
	output logic [sda_pkg::COL_W-1:0]        out_col,
	output logic                             last_of_row,
	output logic                             row_masked
);
	import sda_pkg::*;

	localparam int QA_W   = (MAX_SEQ * MAX_HEAD > 1) ? $clog2(MAX_SEQ * MAX_HEAD) : 1;
	localparam int MA_W   = (MAX_SEQ * MAX_SEQ > 1) ? $clog2(MAX_SEQ * MAX_SEQ) : 1;
	localparam int SI_W   = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
	localparam int HI_W   = (MAX_HEAD > 1) ? $clog2(MAX_HEAD) : 1;
	localparam int DP_W   = 2 * DATA_WIDTH;
	localparam int DOT_W  = DP_W + 7;
	localparam int SHI_W  = DOT_W - 21;
	localparam int PHI_W  = SHI_W + 17;
	localparam int FULL_W = DOT_W + 18;
	localparam int SC_W   = DOT_W - 4;
	localparam int D_W    = SC_W + 1;
	localparam int X_W    = D_W + 18;
	localparam int E_W    = 17;
	localparam int SUM_W  = E_W + SI_W + 1;
	localparam int PP_W   = 2 * E_W;
	localparam int OV_W   = E_W + 1 + DATA_WIDTH;
	localparam int OA_W   = OV_W + SI_W + 1;

	localparam logic signed [DATA_WIDTH-1:0] MASK_NEG_INF = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [OA_W-1:0] SAT_HI = OA_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [OA_W-1:0] SAT_LO = OA_W'(-(64'sd1 <<< (DATA_WIDTH - 1)));

	logic [ROW_W-1:0]             row_q;
	logic signed [DP_W-1:0]       dprod_q;
	logic signed [DOT_W-1:0]      dacc_q;
	logic [36:0]                  plo_q;
	logic signed [PHI_W-1:0]      phi_q;
	logic signed [SC_W-1:0]       raw_q;
	logic signed [SC_W-1:0]       score_q;
	logic                         mk_q;
	logic signed [SC_W-1:0]       max_q;
	logic                         any_q;
	logic                         mk2_q;
	logic signed [X_W-1:0]        xp_q;
	logic [15:0]                  f_q;
	logic [4:0]                   n_q;
	logic                         big_q;
	logic [31:0]                  c1_q;
	logic [31:0]                  ff_q;
	logic [45:0]                  c2_q;
	logic [SUM_W-1:0]             sum_q;
	logic [SUM_W-1:0]             rem_q;
	logic [E_W-1:0]               rec_q;
	logic [PP_W-1:0]              pp_q;
	logic signed [OV_W-1:0]       ov_q;
	logic signed [OA_W-1:0]       oa_q;
	logic signed [OUT_W-1:0]      out_value_q;
	logic [COL_W-1:0]             out_col_q;
	logic                         last_q;
	logic                         rowm_q;

	logic                         ld_qkv_ok;
	logic                         ld_m_ok;
	logic [QA_W-1:0]              ld_qa;
	logic [MA_W-1:0]              ld_ma;
	logic [QA_W-1:0]              q_raddr;
	logic [QA_W-1:0]              k_raddr;
	logic [QA_W-1:0]              v_raddr;
	logic [MA_W-1:0]              m_raddr;
	logic signed [DATA_WIDTH-1:0] q_rdata;
	logic signed [DATA_WIDTH-1:0] k_rdata;
	logic signed [DATA_WIDTH-1:0] v_rdata;
	logic signed [DATA_WIDTH-1:0] m_rdata;
	logic [SC_W:0]                s_rdata;
	logic [E_W-1:0]               p_rdata;
	logic                         p_we;
	logic [E_W-1:0]               p_wdata;
	logic [SI_W-1:0]              p_raddr;

	logic signed [FULL_W-1:0]     sc_full;
	logic                         sc_mk;
	logic signed [SC_W-1:0]       sc_val;
	logic                         any_base;
	logic                         take;
	logic signed [D_W-1:0]        ex_d;
	logic signed [X_W-1:0]        ex_t;
	logic [X_W-1:0]               ex_u;
	logic [17:0]                  ex_p;
	logic [E_W-1:0]               ex_e;
	logic [SUM_W:0]               dv_r2;
	logic [E_W-1:0]               prob_val;
	logic signed [OA_W-1:0]       o_rnd;
	logic signed [OA_W-1:0]       o_sat;

	assign ld_qkv_ok = (int'(in_row) < MAX_SEQ) && (int'(in_col) < MAX_HEAD);
	assign ld_m_ok   = (int'(in_row) < MAX_SEQ) && (int'(in_col) < MAX_SEQ);
	assign ld_qa     = QA_W'(in_row) * QA_W'(MAX_HEAD) + QA_W'(in_col);
	assign ld_ma     = MA_W'(in_row) * MA_W'(MAX_SEQ) + MA_W'(in_col);

	assign q_raddr = QA_W'(row_q) * QA_W'(MAX_HEAD) + QA_W'(cmd.k[HI_W-1:0]);
	assign k_raddr = QA_W'(cmd.j[SI_W-1:0]) * QA_W'(MAX_HEAD) + QA_W'(cmd.k[HI_W-1:0]);
	assign v_raddr = QA_W'(cmd.k[SI_W-1:0]) * QA_W'(MAX_HEAD) + QA_W'(cmd.j[HI_W-1:0]);
	assign m_raddr = MA_W'(row_q) * MA_W'(MAX_SEQ) + MA_W'(cmd.j[SI_W-1:0]);

	sda_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_SEQ * MAX_HEAD)) u_q_ram (
		.clk   (clk),
		.we    (cmd.load && (in_func == FN_LOAD_Q) && ld_qkv_ok),
		.waddr (ld_qa),
		.wdata (in_value),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	sda_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_SEQ * MAX_HEAD)) u_k_ram (
		.clk   (clk),
		.we    (cmd.load && (in_func == FN_LOAD_K) && ld_qkv_ok),
		.waddr (ld_qa),
		.wdata (in_value),
		.raddr (k_raddr),
		.rdata (k_rdata)
	);

	sda_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_SEQ * MAX_HEAD)) u_v_ram (
		.clk   (clk),
		.we    (cmd.load && (in_func == FN_LOAD_V) && ld_qkv_ok),
		.waddr (ld_qa),
		.wdata (in_value),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	sda_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_SEQ * MAX_SEQ)) u_m_ram (
		.clk   (clk),
		.we    (cmd.load && (in_func == FN_LOAD_M) && ld_m_ok),
		.waddr (ld_ma),
		.wdata (in_value),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	sda_ram #(.WIDTH(SC_W + 1), .DEPTH(MAX_SEQ)) u_s_ram (
		.clk   (clk),
		.we    (cmd.op == OP_SC4),
		.waddr (cmd.j[SI_W-1:0]),
		.wdata ({mk_q, score_q}),
		.raddr (cmd.j[SI_W-1:0]),
		.rdata (s_rdata)
	);

	assign p_we    = (cmd.op == OP_EX_E) || (cmd.op == OP_PR_WR);
	assign p_wdata = (cmd.op == OP_EX_E) ? ex_e : prob_val;
	assign p_raddr = (cmd.op == OP_OUT_RD) ? cmd.k[SI_W-1:0] : cmd.j[SI_W-1:0];

	sda_ram #(.WIDTH(E_W), .DEPTH(MAX_SEQ)) u_p_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (cmd.j[SI_W-1:0]),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	always_comb begin
		sc_full = (FULL_W'(phi_q) <<< 21) + $signed(FULL_W'(plo_q)) + FULL_W'(2097152);
		sc_mk   = causal && (cmd.j > CNT_W'(row_q));
		sc_val  = raw_q;
		if (mask_en) begin
			if (m_rdata == MASK_NEG_INF) begin
				sc_mk = 1'b1;
			end else begin
				sc_val = raw_q + (SC_W'(m_rdata) <<< 4);
			end
		end
		any_base = cmd.first ? 1'b0 : any_q;
		take     = !mk_q && (!any_base || (score_q > max_q));
		ex_d     = D_W'($signed(s_rdata[SC_W-1:0])) - D_W'(max_q);
		ex_t     = (xp_q + X_W'(32768)) >>> 16;
		ex_u     = (ex_t < 0) ? X_W'(-ex_t) : '0;
		ex_p     = 18'd65536 - 18'(c1_q[31:16]) + 18'(c2_q[45:32]);
		ex_e     = (big_q || mk2_q) ? '0 : E_W'(ex_p >> n_q);
		dv_r2    = {rem_q, cmd.first};
		prob_val = E_W'((pp_q + PP_W'(32768)) >> 16);
		o_rnd    = (oa_q + OA_W'(32768)) >>> 16;
		if (o_rnd > SAT_HI) begin
			o_sat = SAT_HI;
		end else if (o_rnd < SAT_LO) begin
			o_sat = SAT_LO;
		end else begin
			o_sat = o_rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
			max_q <= '0;
		end else if (cmd.op == OP_SC4) begin
			any_q <= any_base || take;
			if (take) begin
				max_q <= score_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START:   row_q <= in_row;
			OP_DOT_MUL: dprod_q <= q_rdata * k_rdata;
			OP_DOT_ACC: dacc_q <= cmd.first ? DOT_W'(dprod_q) : dacc_q + DOT_W'(dprod_q);
			OP_SC1: begin
				plo_q <= dacc_q[20:0] * scale;
				phi_q <= $signed(dacc_q[DOT_W-1:21]) * $signed({1'b0, scale});
			end
			OP_SC2:     raw_q <= SC_W'(sc_full >>> 22);
			OP_SC3: begin
				score_q <= sc_val;
				mk_q    <= sc_mk;
			end
			OP_EX_A: begin
				mk2_q <= s_rdata[SC_W];
				xp_q  <= ex_d * $signed({1'b0, LOG2E_Q16});
			end
			OP_EX_B: begin
				f_q   <= ex_u[15:0];
				n_q   <= ex_u[20:16];
				big_q <= |ex_u[X_W-1:21];
			end
			OP_EX_C: begin
				c1_q <= EXP_C1 * f_q;
				ff_q <= f_q * f_q;
			end
			OP_EX_D:    c2_q <= EXP_C2 * ff_q;
			OP_EX_E:    sum_q <= cmd.first ? SUM_W'(ex_e) : sum_q + SUM_W'(ex_e);
			OP_DIV_INIT: begin
				rem_q <= '0;
				rec_q <= '0;
			end
			OP_DIV_STEP: begin
				if (dv_r2 >= {1'b0, sum_q}) begin
					rem_q <= SUM_W'(dv_r2 - {1'b0, sum_q});
					rec_q <= {rec_q[E_W-2:0], 1'b1};
				end else begin
					rem_q <= SUM_W'(dv_r2);
					rec_q <= {rec_q[E_W-2:0], 1'b0};
				end
			end
			OP_PR_MUL:  pp_q <= p_rdata * rec_q;
			OP_OUT_MUL: ov_q <= $signed({1'b0, p_rdata}) * v_rdata;
			OP_OUT_ACC: oa_q <= cmd.first ? OA_W'(ov_q) : oa_q + OA_W'(ov_q);
			OP_OUT_RND: begin
				out_value_q <= o_sat[OUT_W-1:0];
				out_col_q   <= cmd.j[COL_W-1:0];
				last_q      <= cmd.last;
				rowm_q      <= 1'b0;
			end
			OP_OUT_ZERO: begin
				out_value_q <= '0;
				out_col_q   <= cmd.j[COL_W-1:0];
				last_q      <= cmd.last;
				rowm_q      <= 1'b1;
			end
			default: ;
		endcase
	end

	assign sts.any     = any_q;
	assign out_value   = out_value_q;
	assign out_col     = out_col_q;
	assign last_of_row = last_q;
	assign row_masked  = rowm_q;

endmodule

// ===== rtl/scaled_dot_product_attention_unit.sv =====
// Load beats are written into the stores while the sequencer is idle. A compute row walks
// the stores with sequential multiply-accumulate loops and the one-bit-per-cycle reciprocal,
// and any output stall lengthens it.
// One item is worked at a time; each result is held in an output register until taken.
// Reset restores the configuration defaults and idles the sequencer; stores keep no reset.
module scaled_dot_product_attention_unit #(
	parameter int MAX_SEQ    = 64,
	parameter int MAX_HEAD   = 64,
	parameter int DATA_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sda_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [sda_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [sda_pkg::FUNC_W-1:0]           func,
	input  logic [sda_pkg::ROW_W-1:0]            row_index,
	input  logic [sda_pkg::COL_W-1:0]            col_index,
	input  logic signed [DATA_WIDTH-1:0]         in_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [sda_pkg::OUT_W-1:0]     out_value,
	output logic [sda_pkg::COL_W-1:0]            out_col,
	output logic                                 last_of_row,
	output logic                                 row_masked
);
	import sda_pkg::*;

	logic [6:0]       seq_q;
	logic [6:0]       head_q;
	logic [15:0]      scale_q;
	logic             causal_q;
	logic             mask_en_q;
	logic [CNT_W-1:0] sl;
	logic [CNT_W-1:0] hd;
	cmd_t             cmd;
	sts_t             sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= 7'd64;
			head_q    <= 7'd64;
			scale_q   <= 16'd2048;
			causal_q  <= 1'b0;
			mask_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SEQ:    seq_q     <= cfg_wdata[6:0];
				REG_HEAD:   head_q    <= cfg_wdata[6:0];
				REG_SCALE:  scale_q   <= cfg_wdata;
				REG_CAUSAL: causal_q  <= cfg_wdata[0];
				REG_MASK:   mask_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (seq_q == '0) begin
			sl = CNT_W'(1);
		end else if (int'(seq_q) > MAX_SEQ) begin
			sl = CNT_W'(MAX_SEQ);
		end else begin
			sl = CNT_W'(seq_q);
		end
		if (head_q == '0) begin
			hd = CNT_W'(1);
		end else if (int'(head_q) > MAX_HEAD) begin
			hd = CNT_W'(MAX_HEAD);
		end else begin
			hd = CNT_W'(head_q);
		end
	end

	sda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (func),
		.in_row    (row_index),
		.sl        (sl),
		.hd        (hd),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	sda_datapath #(
		.MAX_SEQ    (MAX_SEQ),
		.MAX_HEAD   (MAX_HEAD),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_func     (func),
		.in_row      (row_index),
		.in_col      (col_index),
		.in_value    (in_value),
		.scale       (scale_q),
		.causal      (causal_q),
		.mask_en     (mask_en_q),
		.out_value   (out_value),
		.out_col     (out_col),
		.last_of_row (last_of_row),
		.row_masked  (row_masked)
	);

endmodule
